// ===== rtl/core/grls_pkg.sv =====
// Shared constants and types for the gradient ramp sampler.
`timescale 1ns / 1ps
`default_nettype none
package grls_pkg;

  localparam int MaxStops   = 16;
  localparam int MaxSamples = 4096;
  localparam int AddrW      = $clog2(MaxStops);
  localparam int CntW       = $clog2(MaxStops + 1);
  localparam int SampW      = $clog2(MaxSamples + 1);
  localparam int IdxW       = $clog2(MaxSamples);
  localparam int PosW       = 17;
  localparam int ChanW      = 8;
  localparam int StatW      = 2;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 13;

  // bit-serial divider lengths
  localparam int UDivW      = IdxW + 16;          // dividend of the position divide
  localparam int LDivW      = PosW + ChanW;       // dividend of the channel divide
  localparam int IterW      = $clog2((UDivW > LDivW) ? UDivW : LDivW);

  localparam logic [PosW-1:0] Q16One = PosW'(65536);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegSampleCount = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegStopCount   = CfgIdxW'(1);

  // status codes
  localparam logic [StatW-1:0] StOk        = 2'd0;
  localparam logic [StatW-1:0] StFewStops  = 2'd1;
  localparam logic [StatW-1:0] StFirstBad  = 2'd2;
  localparam logic [StatW-1:0] StLastBad   = 2'd3;

  // item mode
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeEval = 1'b1;

  typedef struct packed {
    logic [3:0][ChanW-1:0] col;   // [0] red .. [3] alpha
    logic [PosW-1:0]       pos;
  } stop_t;

endpackage
`default_nettype wire

// ===== rtl/core/gradient_ramp_lut_sampler.sv =====
// Top level: colour-stop table with bit-serial gradient evaluation.
`timescale 1ns / 1ps
`default_nettype none
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | in_tdata (stop fields, sample_index), in_tuser
//  out_    | master    | out_tvalid/out_tready| out_tdata (rgba, status)
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// A load item is written to the stop table as it is accepted; the engine stays idle.
// An evaluate item steps through S_CHK0 and S_CHK1 (stop checks), S_UDIV (bit-serial
// index-to-position divide), S_SCAN0 and S_SCAN (stop pairs 1..15 scanned through
// the registered table read port), S_LDIV (four parallel bit-serial channel divides)
// and S_DONE (output load); it is back in S_IDLE, ready for the next item, after
// S_DONE. A bad status skips straight to S_DONE. Reset (rst_n low, synchronous)
// clears the state, output valid and config registers; other registers and the
// stop table are not cleared. A finished result waits in the output register while
// the next item is accepted; the engine only stalls when a second result is ready.
module gradient_ramp_lut_sampler (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [3:0] stop_index, [20:4] stop_position, [28:21] stop_red, [36:29] stop_green,
  // [44:37] stop_blue, [52:45] stop_alpha, [64:53] sample_index, rest zero
  input  wire logic [71:0]                     in_tdata,
  // [0] mode
  input  wire logic                            in_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] out_alpha,
  // [33:32] status, rest zero
  output logic [39:0]                          out_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [grls_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic [grls_pkg::CfgDataW-1:0]   cfg_data
);
  import grls_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CHK0, S_CHK1, S_UDIV, S_SCAN0, S_SCAN, S_LDIV, S_DONE
  } state_t;

  // unpack input item
  logic [AddrW-1:0] i_slot;
  logic [PosW-1:0]  i_pos;
  logic [3:0][ChanW-1:0] i_col;
  logic [IdxW-1:0]  i_sidx;
  assign i_slot   = in_tdata[3:0];
  assign i_pos    = in_tdata[20:4];
  assign i_col[0] = in_tdata[28:21];
  assign i_col[1] = in_tdata[36:29];
  assign i_col[2] = in_tdata[44:37];
  assign i_col[3] = in_tdata[52:45];
  assign i_sidx   = in_tdata[64:53];

  // configuration registers
  logic [CfgDataW-1:0] sample_count_r;
  logic [CntW-1:0]     stop_count_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= CfgDataW'(256);
      stop_count_r   <= CntW'(2);
    end else if (cfg_valid) begin
      case (cfg_index)
        RegSampleCount: sample_count_r <= cfg_data;
        RegStopCount:   stop_count_r   <= cfg_data[CntW-1:0];
        default: ;
      endcase
    end
  end

  // stop table memory
  stop_t            stop_mem [MaxStops];
  stop_t            rd_q_r;
  logic [AddrW-1:0] rd_addr;
  logic             in_acc;
  stop_t            wr_ent;

  assign in_acc     = in_tvalid && in_tready;
  assign wr_ent.pos = i_pos;
  assign wr_ent.col = i_col;

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == ModeLoad) begin
      stop_mem[i_slot] <= wr_ent;
    end
    rd_q_r <= stop_mem[rd_addr];
  end

  // engine registers
  state_t               state_r, state_nxt;
  logic [CntW-1:0]      cnt_r, cnt_nxt;
  logic [IdxW-1:0]      dv_r, dv_nxt;            // clamped sample_count - 1
  logic [UDivW-1:0]     ush_r, ush_nxt;          // dividend shift
  logic [IdxW-1:0]      urem_r, urem_nxt;
  logic [PosW-1:0]      u_r, u_nxt;
  logic [IterW-1:0]     it_r, it_nxt;
  logic [AddrW-1:0]     k_r, k_nxt;
  stop_t                prev_r, prev_nxt;
  logic [PosW-1:0]      den_r, den_nxt;
  logic                 zden_r, zden_nxt;
  logic [3:0][LDivW-1:0] lsh_r, lsh_nxt;
  logic [3:0][PosW-1:0]  lrem_r, lrem_nxt;
  logic [3:0][ChanW-1:0] lq_r, lq_nxt;
  logic [3:0]            ldn_r, ldn_nxt;         // channel falls from c0 to c1
  logic [3:0][ChanW-1:0] res_r, res_nxt;
  logic [StatW-1:0]      stat_r, stat_nxt;
  logic                  ovld_r, ovld_nxt;
  logic [39:0]           odat_r, odat_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = odat_r;

  // clamped index and divisor for a new evaluate item
  logic [CfgDataW-1:0] n_cl;
  logic [IdxW-1:0]     nm1, idx_cl;
  always_comb begin
    if (sample_count_r < CfgDataW'(2))               n_cl = CfgDataW'(2);
    else if (sample_count_r > CfgDataW'(MaxSamples)) n_cl = CfgDataW'(MaxSamples);
    else                                             n_cl = sample_count_r;
    nm1    = IdxW'(n_cl - CfgDataW'(1));
    idx_cl = (i_sidx > nm1) ? nm1 : i_sidx;
  end

  // position divide step
  logic [IdxW:0]   utry;
  logic            ugo;
  assign utry = {urem_r, ush_r[UDivW-1]};
  assign ugo  = (utry >= {1'b0, dv_r});

  // channel divide steps, one lane per channel
  logic [3:0][PosW:0] ltry;
  logic [3:0]         lgo;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      ltry[c] = {lrem_r[c], lsh_r[c][LDivW-1]};
      lgo[c]  = (ltry[c] >= {1'b0, den_r});
    end
  end

  // interval test and lerp set-up for the stop pair (prev, current)
  logic            hit;
  logic [PosW-1:0] t_off;
  assign hit   = (u_r >= prev_r.pos) && (u_r <= rd_q_r.pos);
  assign t_off = u_r - prev_r.pos;

  logic [3:0][ChanW-1:0] dmag;
  logic [3:0]            dneg;
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      dneg[c] = (rd_q_r.col[c] < prev_r.col[c]);
      dmag[c] = dneg[c] ? (prev_r.col[c] - rd_q_r.col[c])
                        : (rd_q_r.col[c] - prev_r.col[c]);
    end
  end

  // read address follows the state
  always_comb begin
    unique case (state_r)
      S_CHK0:  rd_addr = AddrW'(cnt_r - CntW'(1));
      S_SCAN0: rd_addr = AddrW'(1);
      S_SCAN:  rd_addr = k_r + AddrW'(1);
      default: rd_addr = '0;
    endcase
  end

  // next-state logic
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dv_nxt    = dv_r;
    ush_nxt   = ush_r;
    urem_nxt  = urem_r;
    u_nxt     = u_r;
    it_nxt    = it_r;
    k_nxt     = k_r;
    prev_nxt  = prev_r;
    den_nxt   = den_r;
    zden_nxt  = zden_r;
    lsh_nxt   = lsh_r;
    lrem_nxt  = lrem_r;
    lq_nxt    = lq_r;
    ldn_nxt   = ldn_r;
    res_nxt   = res_r;
    stat_nxt  = stat_r;
    ovld_nxt  = ovld_r;
    odat_nxt  = odat_r;

    if (ovld_r && out_tready) ovld_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && in_tuser == ModeEval) begin
          cnt_nxt  = (stop_count_r > CntW'(MaxStops)) ? CntW'(MaxStops) : stop_count_r;
          dv_nxt   = nm1;
          ush_nxt  = {idx_cl, 16'd0};
          urem_nxt = '0;
          u_nxt    = '0;
          it_nxt   = '0;
          res_nxt  = '0;
          stat_nxt = StOk;
          if (cnt_nxt < CntW'(2)) begin
            stat_nxt  = StFewStops;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_CHK0;
          end
        end
      end
      S_CHK0: begin
        if (rd_q_r.pos != '0) begin
          stat_nxt  = StFirstBad;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_CHK1;
        end
      end
      S_CHK1: begin
        if (rd_q_r.pos != Q16One) begin
          stat_nxt  = StLastBad;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_UDIV;
        end
      end
      S_UDIV: begin
        // one quotient bit per cycle
        urem_nxt = ugo ? IdxW'(utry - {1'b0, dv_r}) : utry[IdxW-1:0];
        u_nxt    = {u_r[PosW-2:0], ugo};
        ush_nxt  = {ush_r[UDivW-2:0], 1'b0};
        it_nxt   = it_r + IterW'(1);
        if (it_r == IterW'(UDivW - 1)) state_nxt = S_SCAN0;
      end
      S_SCAN0: begin
        prev_nxt  = rd_q_r;
        k_nxt     = AddrW'(1);
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          den_nxt  = rd_q_r.pos - prev_r.pos;
          zden_nxt = (rd_q_r.pos == prev_r.pos);
          for (int c = 0; c < 4; c++) begin
            lsh_nxt[c]  = LDivW'(t_off) * LDivW'(dmag[c]);
            lrem_nxt[c] = '0;
            lq_nxt[c]   = '0;
            ldn_nxt[c]  = dneg[c];
          end
          it_nxt    = '0;
          state_nxt = S_LDIV;
        end else if (k_r == AddrW'(cnt_r - CntW'(1))) begin
          state_nxt = S_DONE;
        end else begin
          prev_nxt = rd_q_r;
          k_nxt    = k_r + AddrW'(1);
        end
      end
      S_LDIV: begin
        for (int c = 0; c < 4; c++) begin
          lrem_nxt[c] = lgo[c] ? PosW'(ltry[c] - {1'b0, den_r}) : ltry[c][PosW-1:0];
          lq_nxt[c]   = {lq_r[c][ChanW-2:0], lgo[c]};
          lsh_nxt[c]  = {lsh_r[c][LDivW-2:0], 1'b0};
        end
        it_nxt = it_r + IterW'(1);
        if (it_r == IterW'(LDivW - 1)) begin
          // final quotient and remainder now in the _nxt values
          for (int c = 0; c < 4; c++) begin
            if (zden_r)
              res_nxt[c] = prev_r.col[c];
            else if (ldn_r[c])
              res_nxt[c] = prev_r.col[c] - lq_nxt[c]
                           - ChanW'(lrem_nxt[c] != '0);
            else
              res_nxt[c] = prev_r.col[c] + lq_nxt[c];
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovld_r || out_tready) begin
          ovld_nxt  = 1'b1;
          odat_nxt  = {6'd0, stat_r, res_r[3], res_r[2], res_r[1], res_r[0]};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
    cnt_r  <= cnt_nxt;
    dv_r   <= dv_nxt;
    ush_r  <= ush_nxt;
    urem_r <= urem_nxt;
    u_r    <= u_nxt;
    it_r   <= it_nxt;
    k_r    <= k_nxt;
    prev_r <= prev_nxt;
    den_r  <= den_nxt;
    zden_r <= zden_nxt;
    lsh_r  <= lsh_nxt;
    lrem_r <= lrem_nxt;
    lq_r   <= lq_nxt;
    ldn_r  <= ldn_nxt;
    res_r  <= res_nxt;
    stat_r <= stat_nxt;
    odat_r <= odat_nxt;
  end

endmodule
`default_nettype wire
